// File: src/lsld_pkg.sv
// Package: shared types and constants for the limit switch lockout dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package lsld_pkg;

	localparam int SW_IDX_W = 3;
	localparam int MASK_W   = 8;
	localparam int TICK_W   = 16;
	localparam int CFG_A_W  = 8;
	localparam int CFG_D_W  = 16;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_EVENT  = 2'd1,
		FN_REINIT = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		MODE_OTHER   = 2'd0,
		MODE_HOMING  = 2'd1,
		MODE_PROBING = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_FEEDHOLD = 2'd1,
		ACT_LIMIT    = 2'd2
	} action_t;

	localparam logic [CFG_A_W-1:0] CFG_NC_POLARITY   = 8'd0;
	localparam logic [CFG_A_W-1:0] CFG_ENABLED_MASK  = 8'd1;
	localparam logic [CFG_A_W-1:0] CFG_LIMIT_MASK    = 8'd2;
	localparam logic [CFG_A_W-1:0] CFG_LOCKOUT_TICKS = 8'd3;

	typedef struct packed {
		logic              nc_polarity;
		logic [MASK_W-1:0] enabled_mask;
		logic [MASK_W-1:0] limit_mask;
		logic [TICK_W-1:0] lockout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [SW_IDX_W-1:0] switch_index;
		logic                raw_level;
		logic [1:0]          cycle_mode;
	} item_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [SW_IDX_W-1:0] action_switch;
		logic [MASK_W-1:0]   hit_flags;
	} res_t;

endpackage
`default_nettype wire

// File: src/lsld_in_if.sv
// Interface: input item channel (valid/ready plus item fields).
`timescale 1ns / 1ps
`default_nettype none
interface lsld_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [2:0] switch_index;
	logic       raw_level;
	logic [1:0] cycle_mode;

	modport source (output valid, output func, output switch_index, output raw_level,
		output cycle_mode, input ready);
	modport sink (input valid, input func, input switch_index, input raw_level,
		input cycle_mode, output ready);
endinterface
`default_nettype wire

// File: src/lsld_out_if.sv
// Interface: result channel (valid/ready plus result fields).
`timescale 1ns / 1ps
`default_nettype none
interface lsld_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [2:0] action_switch;
	logic [7:0] hit_flags;

	modport source (output valid, output action, output action_switch, output hit_flags,
		input ready);
	modport sink (input valid, input action, input action_switch, input hit_flags,
		output ready);
endinterface
`default_nettype wire

// File: src/lsld_cfg_if.sv
// Interface: configuration write channel (valid/ready, register address, data).
`timescale 1ns / 1ps
`default_nettype none
interface lsld_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  addr;
	logic [15:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// File: src/limit_switch_lockout_dispatch.sv
// Top level: input register, switch core, result register and config port.
//
// channel  dir  beat carries
// evt      in   func, switch_index, raw_level, cycle_mode
// res      out  action, action_switch, hit_flags
// cfg      in   addr (register index), data
//
// One item per cycle sustained unless res stalls.
// The item is registered, then the core updates switch state and loads res.
// res stalls hold the result; evt keeps accepting while the input stage can drain.
// cfg is always ready. Reset (arst_n low) clears all switch state and lockouts.
`timescale 1ns / 1ps
`default_nettype none
module limit_switch_lockout_dispatch #(
	parameter int NUM_SW = 8
) (
	input logic              clk,
	input logic              arst_n,
	lsld_in_if.sink          evt,
	lsld_out_if.source       res,
	lsld_cfg_if.sink         cfg
);
	import lsld_pkg::*;

	item_t item_s1;
	logic  s1_valid_q;
	res_t  res_q;
	logic  out_valid_q;
	res_t  core_res;
	cfg_t  cfg_val;
	logic  adv;

	assign adv       = s1_valid_q && (!out_valid_q || res.ready);
	assign evt.ready = !s1_valid_q || adv;
	assign cfg.ready = 1'b1;

	lsld_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_addr (cfg.addr),
		.wr_data (cfg.data),
		.cfg     (cfg_val)
	);

	lsld_core #(.NUM_SW(NUM_SW)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_val),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1.func         <= evt.func;
			item_s1.switch_index <= evt.switch_index;
			item_s1.raw_level    <= evt.raw_level;
			item_s1.cycle_mode   <= evt.cycle_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= core_res;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.action        = res_q.action;
	assign res.action_switch = res_q.action_switch;
	assign res.hit_flags     = res_q.hit_flags;

`ifndef SYNTHESIS
	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not loaded after advance");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |=> s1_valid_q && $stable(item_s1))
		else $error("input stage lost a stalled item");

	a_none_switch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.action == ACT_NONE) |-> (res_q.action_switch == '0))
		else $error("action_switch set without action");

	a_limit_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.action == ACT_LIMIT) |-> res_q.hit_flags[res_q.action_switch])
		else $error("limit asserted on a switch not hit");
`endif
endmodule
`default_nettype wire

// File: src/lsld_cfg_regs.sv
// Configuration register file: decodes write beats into the four settings.
`timescale 1ns / 1ps
`default_nettype none
module lsld_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [lsld_pkg::CFG_A_W-1:0]  wr_addr,
	input  logic [lsld_pkg::CFG_D_W-1:0]  wr_data,
	output lsld_pkg::cfg_t                cfg
);
	import lsld_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nc_polarity   <= 1'b0;
			cfg_q.enabled_mask  <= 8'hFF;
			cfg_q.limit_mask    <= 8'h00;
			cfg_q.lockout_ticks <= 16'd50;
		end else if (wr_en) begin
			case (wr_addr)
				CFG_NC_POLARITY:   cfg_q.nc_polarity   <= wr_data[0];
				CFG_ENABLED_MASK:  cfg_q.enabled_mask  <= wr_data[MASK_W-1:0];
				CFG_LIMIT_MASK:    cfg_q.limit_mask    <= wr_data[MASK_W-1:0];
				CFG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= wr_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// File: src/lsld_core.sv
// Switch state, lockout counters and the per-item qualify/dispatch logic.
`timescale 1ns / 1ps
`default_nettype none
module lsld_core #(
	parameter int NUM_SW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  lsld_pkg::item_t item,
	input  lsld_pkg::cfg_t  cfg,
	output lsld_pkg::res_t  res
);
	import lsld_pkg::*;

	localparam int IDX_W = (NUM_SW > 1) ? $clog2(NUM_SW) : 1;
	localparam int EXT_W = (IDX_W > SW_IDX_W) ? IDX_W : SW_IDX_W;

	logic              hit_q  [NUM_SW];
	logic [TICK_W-1:0] lock_q [NUM_SW];
	logic              hit_nxt  [NUM_SW];
	logic [TICK_W-1:0] lock_nxt [NUM_SW];

	logic [EXT_W-1:0] idx_ext;
	logic [IDX_W-1:0] sel;
	logic             in_rng;
	logic             lvl_hit;
	logic             sw_en;
	logic             sw_lim;
	logic             change;
	logic [1:0]       act;

	assign idx_ext = EXT_W'(item.switch_index);
	assign sel     = idx_ext[IDX_W-1:0];
	assign in_rng  = (32'(item.switch_index) < NUM_SW);
	// normally open (polarity 0) inverts the pin
	assign lvl_hit = item.raw_level ^ ~cfg.nc_polarity;
	assign sw_en   = cfg.enabled_mask[item.switch_index];
	assign sw_lim  = cfg.limit_mask[item.switch_index];
	assign change  = (item.func == FN_EVENT) && in_rng && sw_en &&
		(lock_q[sel] == '0) && (hit_q[sel] != lvl_hit);

	always_comb begin
		act = ACT_NONE;
		if (change) begin
			if (item.cycle_mode == MODE_HOMING) begin
				act = ACT_FEEDHOLD;
			end else if (lvl_hit) begin
				if (item.cycle_mode == MODE_PROBING) begin
					act = ACT_FEEDHOLD;
				end else if (sw_lim) begin
					act = ACT_LIMIT;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_SW; i++) begin
			hit_nxt[i]  = hit_q[i];
			lock_nxt[i] = lock_q[i];
			if (item.func == FN_TICK) begin
				if (lock_q[i] != '0) begin
					lock_nxt[i] = lock_q[i] - TICK_W'(1);
				end
			end else if (idx_ext == EXT_W'(i)) begin
				if (change) begin
					hit_nxt[i]  = lvl_hit;
					lock_nxt[i] = cfg.lockout_ticks;
				end else if ((item.func == FN_REINIT) && in_rng) begin
					hit_nxt[i]  = sw_en & lvl_hit;
					lock_nxt[i] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SW; i++) begin
				hit_q[i]  <= 1'b0;
				lock_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = 0; i < NUM_SW; i++) begin
				hit_q[i]  <= hit_nxt[i];
				lock_q[i] <= lock_nxt[i];
			end
		end
	end

	logic [MASK_W-1:0] flags;

	for (genvar b = 0; b < MASK_W; b++) begin : g_flags
		if (b < NUM_SW) begin : g_on
			assign flags[b] = hit_nxt[b];
		end else begin : g_off
			assign flags[b] = 1'b0;
		end
	end

	assign res.action        = act;
	assign res.action_switch = (act != ACT_NONE) ? item.switch_index : '0;
	assign res.hit_flags     = flags;
endmodule
`default_nettype wire
